>>> rtl/core/ssp_pkg.sv
// Shared types and constants of the sine sweep phase generator.
// No dependencies; compile first.
`timescale 1ns / 1ps

package ssp_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_MODE      = 3'd0;
	localparam logic [2:0] REG_FREQ_STEP = 3'd1;
	localparam logic [2:0] REG_FREQ_MAX  = 3'd2;
	localparam logic [2:0] REG_SWEEP_F0  = 3'd3;
	localparam logic [2:0] REG_SWEEP_RT  = 3'd4;

	localparam logic [15:0] FREQ_STEP_RST = 16'd256;
	localparam logic [7:0]  FREQ_MAX_RST  = 8'd150;
	localparam logic [14:0] SWEEP_F0_RST  = 15'd256;
	localparam logic [14:0] SWEEP_RT_RST  = 15'd256;

	// phase in Q3.12 rad
	localparam logic signed [15:0] PI_Q12     = 16'sd12868;
	localparam logic signed [15:0] TWO_PI_Q12 = 16'sd25736;

	localparam logic [12:0] STEP_PERIOD = 13'd4000;
	localparam logic [15:0] SWEEP_CAP   = 16'd25600;

	// f*t*25736/256000 = f*t*3217/32000 = ((f*t*3217 + 16000) >> 8) / 125
	localparam logic [11:0] PH_MUL    = 12'd3217;
	localparam logic [44:0] PH_BIAS   = 45'd16000;
	// x/2000 = ((x + 1000) >> 4) / 125
	localparam logic [44:0] RR_BIAS   = 45'd1000;
	localparam logic [17:0] RECIP_125 = 18'd134218;
	localparam logic [6:0]  DIV_125   = 7'd125;

	localparam logic [4:0] REP10  = 5'd10;
	localparam logic [6:0] REP100 = 7'd100;

	// parabolic sine
	localparam logic signed [16:0] SIN_B   = 17'sd20861;
	localparam logic [12:0]        SIN_C   = 13'd6640;
	localparam logic signed [31:0] SIN_P   = 32'sd3686;
	localparam logic [16:0]        ONE_Q14 = 17'd16384;

	typedef struct packed {
		logic [15:0]        phase_ticks;
		logic [12:0]        step_ticks;
		logic [15:0]        stepped_freq;
		logic signed [15:0] stepped_ofs;
		logic [15:0]        sweep_fofs;
		logic signed [15:0] sweep_ofs;
	} entry_t;

	localparam entry_t ENTRY_RST = '{
		phase_ticks:  16'd0,
		step_ticks:   13'd0,
		stepped_freq: 16'd256,
		stepped_ofs:  16'sd0,
		sweep_fofs:   16'd0,
		sweep_ofs:    16'sd0
	};

	typedef struct packed {
		logic               done;
		logic signed [15:0] value;
	} sine_res_t;

endpackage

>>> rtl/core/ssp_in_if.sv
// Input channel of the sine sweep phase generator: tick or joint reset item.
// No dependencies.
`timescale 1ns / 1ps

interface ssp_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [1:0] joint;

	modport source (output valid, output operation, output joint, input ready);
	modport sink (input valid, input operation, input joint, output ready);
endinterface

>>> rtl/core/ssp_out_if.sv
// Result channel of the sine sweep phase generator.
// No dependencies.
`timescale 1ns / 1ps

interface ssp_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         joint_out;
	logic signed [15:0] phase;
	logic signed [15:0] sine_value;
	logic [13:0]        freq_report;

	modport source (output valid, output joint_out, output phase, output sine_value,
		output freq_report, input ready);
	modport sink (input valid, input joint_out, input phase, input sine_value,
		input freq_report, output ready);
endinterface

>>> rtl/core/ssp_sine.sv
// Multi-cycle parabolic sine evaluator, Q3.12 phase in, Q1.14 sine out.
// Depends on ssp_pkg.
`timescale 1ns / 1ps

module ssp_sine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [15:0]  x,
	output ssp_pkg::sine_res_t  res
);
	import ssp_pkg::*;

	typedef enum logic [8:0] {
		SN_IDLE = 9'b000000001,
		SN_M1   = 9'b000000010,
		SN_T1   = 9'b000000100,
		SN_M2   = 9'b000001000,
		SN_Y    = 9'b000010000,
		SN_M3   = 9'b000100000,
		SN_G    = 9'b001000000,
		SN_M4   = 9'b010000000,
		SN_OUT  = 9'b100000000
	} sn_state_t;

	sn_state_t          state_q;
	logic [16:0]        a_q;
	logic               xneg_q;
	logic [27:0]        sm_q;
	logic signed [16:0] t1_q;
	logic signed [34:0] p2_q;
	logic [17:0]        ymag_q;
	logic               yneg_q;
	logic signed [31:0] gm_q;
	logic [16:0]        g_q;
	logic [34:0]        yg_q;
	logic signed [15:0] value_q;

	logic signed [16:0] xe;
	logic [27:0]        sm_r;
	logic [34:0]        p2_mag;
	logic [34:0]        p2_r;
	logic signed [18:0] d;
	logic [31:0]        gm_mag;
	logic [31:0]        gm_r;
	logic [34:0]        yg_r;
	logic [14:0]        cl;

	always_comb begin
		xe     = {x[15], x};
		sm_r   = sm_q + 28'd2048;
		p2_mag = p2_q[34] ? 35'(-p2_q) : 35'(p2_q);
		p2_r   = p2_mag + 35'd2048;
		d      = $signed({1'b0, ymag_q}) - $signed({2'b00, ONE_Q14});
		gm_mag = gm_q[31] ? 32'(-gm_q) : 32'(gm_q);
		gm_r   = gm_mag + 32'd8192;
		yg_r   = yg_q + 35'd8192;
		cl     = (yg_r[34:14] > 21'(ONE_Q14)) ? ONE_Q14[14:0] : yg_r[28:14];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SN_IDLE;
		end else begin
			case (state_q)
				SN_IDLE: if (start) state_q <= SN_M1;
				SN_M1:   state_q <= SN_T1;
				SN_T1:   state_q <= SN_M2;
				SN_M2:   state_q <= SN_Y;
				SN_Y:    state_q <= SN_M3;
				SN_M3:   state_q <= SN_G;
				SN_G:    state_q <= SN_M4;
				SN_M4:   state_q <= SN_OUT;
				SN_OUT:  state_q <= SN_IDLE;
				default: state_q <= SN_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SN_IDLE: begin
				if (start) begin
					a_q    <= x[15] ? 17'(-xe) : 17'(xe);
					xneg_q <= x[15];
				end
			end
			SN_M1: sm_q <= 28'(a_q) * 28'(SIN_C);
			SN_T1: t1_q <= SIN_B - $signed({1'b0, sm_r[27:12]});
			SN_M2: p2_q <= $signed({1'b0, a_q}) * t1_q;
			SN_Y: begin
				ymag_q <= p2_r[29:12];
				yneg_q <= p2_q[34] ^ xneg_q;
			end
			SN_M3: gm_q <= 32'(d) * SIN_P;
			SN_G: begin
				if (gm_q[31])
					g_q <= ONE_Q14 - {1'b0, gm_r[29:14]};
				else
					g_q <= ONE_Q14 + {1'b0, gm_r[29:14]};
			end
			SN_M4: yg_q <= 35'(ymag_q) * 35'(g_q);
			SN_OUT: value_q <= yneg_q ? -$signed({1'b0, cl}) : $signed({1'b0, cl});
			default: ;
		endcase
	end

	assign res.done  = (state_q == SN_OUT);
	assign res.value = value_q;

endmodule

>>> rtl/core/sine_sweep_phase_generator_top.sv
// Top level of the sine sweep phase generator: per-joint state memory,
// item sequencer, divide-by-125 unit. Depends on ssp_pkg, ssp_in_if,
// ssp_out_if and ssp_sine.
//
// Usage: the item channel carries a 1 ms tick (operation 0) or a joint
// reset (operation 1) for one joint; each item gives exactly one item on
// the result channel: joint, wrapped phase (Q3.12), parabolic sine of that
// phase (Q1.14) and the frequency report. The user must write registers
// over wr_en/wr_index/wr_data only while idle, unchecked by the block.
// Timing: one item at a time. The state of a joint is read from a
// synchronous memory, updated by a sequencer that shares one reciprocal
// divide-by-125 unit and a multi-cycle sine evaluator, then written back.
// Stepped mode divides for the phase only; sweep mode divides first for
// the frequency offset, then for the phase, and again when the sweep
// phase wraps. A reset item or a joint beyond JOINTS skips to write-back.
// The next item can be accepted in the cycle after the result is registered.
// Reset: all joints read their reset state through per-joint valid bits,
// no clearing pass; registers take their reset values.
// Stall: the finished result waits in the output register; a following
// item is still accepted and processed, and holds at write-back until the
// output register is free.
`timescale 1ns / 1ps

module sine_sweep_phase_generator_top #(
	parameter int JOINTS = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	ssp_in_if.sink          item,
	ssp_out_if.source       result,
	input  logic            wr_en,
	input  logic [2:0]      wr_index,
	input  logic [15:0]     wr_data
);
	import ssp_pkg::*;

	localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_RD   = 12'b000000000010,
		S_FSW  = 12'b000000000100,
		S_MUL1 = 12'b000000001000,
		S_MUL2 = 12'b000000010000,
		S_PREP = 12'b000000100000,
		S_DIVA = 12'b000001000000,
		S_DIVB = 12'b000010000000,
		S_WRAP = 12'b000100000000,
		S_UPD  = 12'b001000000000,
		S_SINE = 12'b010000000000,
		S_FIN  = 12'b100000000000
	} state_t;

	typedef enum logic [1:0] {
		PASS_RR  = 2'd0,
		PASS_PH  = 2'd1,
		PASS_RR2 = 2'd2
	} pass_t;

	state_t             state_q;
	pass_t              pass_q;
	logic [JOINTS-1:0]  vld_q;
	logic               ov_q;
	logic               sine_go_q;

	logic               mode_q;
	logic [15:0]        fstep_q;
	logic [7:0]         fmax_q;
	logic [14:0]        f0_q;
	logic [14:0]        rate_q;

	entry_t             mem [JOINTS];
	entry_t             rd_q;
	entry_t             ent_q;
	logic               op_q;
	logic               inr_q;
	logic [1:0]         joint_q;
	logic [AW-1:0]      ra_q;
	logic [15:0]        f_q;
	logic [43:0]        prod_q;
	logic [22:0]        m_q;
	logic [40:0]        rcp_q;
	logic [16:0]        q_q;
	logic signed [15:0] wt_q;
	logic [13:0]        rep_q;

	logic [1:0]         oj_q;
	logic signed [15:0] oph_q;
	logic signed [15:0] osn_q;
	logic [13:0]        orp_q;

	sine_res_t          sres;

	logic               acc;
	logic               inr;
	logic               hit;
	logic               load;
	logic               mem_we;
	logic               mem_re;
	entry_t             ent_rd;
	logic [44:0]        psum;
	logic [40:0]        pshr;
	logic [16:0]        q0;
	logic [23:0]        chk;
	logic [17:0]        fs;
	logic signed [17:0] wsum;
	logic signed [15:0] wt_c;
	logic signed [15:0] wt_n;
	logic               wrap;
	logic [15:0]        t1;
	logic [12:0]        st1;
	logic [16:0]        nf17;
	logic [15:0]        nf;
	logic [15:0]        fcap;
	logic [22:0]        rep100;
	logic [19:0]        rep10;
	logic [17:0]        fo_sum;

	always_comb begin
		acc    = item.valid && item.ready;
		inr    = 32'(item.joint) < JOINTS;
		hit    = !op_q && inr_q;
		load   = !ov_q || result.ready;
		mem_re = acc && inr;
		mem_we = (state_q == S_FIN) && load && hit;
		ent_rd = vld_q[ra_q] ? rd_q : ENTRY_RST;

		psum = 45'(prod_q) + ((pass_q == PASS_PH) ? PH_BIAS : RR_BIAS);
		pshr = (pass_q == PASS_PH) ? 41'(psum[44:8]) : psum[44:4];

		q0  = rcp_q[40:24];
		chk = 24'(q0) * 24'(DIV_125);

		fs = 18'(f0_q) + 18'(ent_q.sweep_fofs) + 18'(q_q);

		wsum = $signed({1'b0, q_q}) +
			$signed(mode_q ? {{2{ent_q.sweep_ofs[15]}}, ent_q.sweep_ofs}
			               : {{2{ent_q.stepped_ofs[15]}}, ent_q.stepped_ofs});
		if (wsum > 18'sd32767)
			wt_c = 16'sd32767;
		else if (wsum < -18'sd32768)
			wt_c = -16'sd32768;
		else
			wt_c = wsum[15:0];
		wrap = wt_c >= PI_Q12;
		wt_n = wrap ? wt_c - TWO_PI_Q12 : wt_c;

		t1  = (ent_q.phase_ticks == 16'hFFFF) ? ent_q.phase_ticks : ent_q.phase_ticks + 16'd1;
		st1 = (ent_q.step_ticks == 13'h1FFF) ? ent_q.step_ticks : ent_q.step_ticks + 13'd1;

		nf17 = 17'(ent_q.stepped_freq) + 17'(fstep_q);
		nf   = nf17[16] ? 16'hFFFF : nf17[15:0];
		fcap = {fmax_q, 8'h00};

		rep100 = 23'(f_q) * 23'(REP100);
		rep10  = 20'(f_q) * 20'(REP10);

		fo_sum = 18'(ent_q.sweep_fofs) + 18'(q_q);
	end

	// per-joint state memory
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[ra_q] <= ent_q;
		if (mem_re)
			rd_q <= mem[AW'(item.joint)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			vld_q     <= '0;
			ov_q      <= 1'b0;
			sine_go_q <= 1'b0;
			mode_q    <= 1'b0;
			fstep_q   <= FREQ_STEP_RST;
			fmax_q    <= FREQ_MAX_RST;
			f0_q      <= SWEEP_F0_RST;
			rate_q    <= SWEEP_RT_RST;
		end else begin
			sine_go_q <= (state_q == S_UPD) || (state_q == S_WRAP && !(mode_q && wrap));
			case (state_q)
				S_IDLE: if (acc) state_q <= S_RD;
				S_RD: begin
					if (hit) begin
						state_q <= mode_q ? S_PREP : S_MUL1;
					end else begin
						if (inr_q)
							vld_q[ra_q] <= 1'b0;
						state_q <= S_FIN;
					end
				end
				S_FSW:  state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_PREP;
				S_PREP: state_q <= S_DIVA;
				S_DIVA: state_q <= S_DIVB;
				S_DIVB: begin
					case (pass_q)
						PASS_RR:  state_q <= S_FSW;
						PASS_PH:  state_q <= S_WRAP;
						PASS_RR2: state_q <= S_UPD;
						default:  state_q <= S_WRAP;
					endcase
				end
				S_WRAP: begin
					if (mode_q && wrap)
						state_q <= S_PREP;
					else
						state_q <= S_SINE;
				end
				S_UPD:  state_q <= S_SINE;
				S_SINE: if (sres.done) state_q <= S_FIN;
				S_FIN: begin
					if (load) begin
						state_q <= S_IDLE;
						if (hit)
							vld_q[ra_q] <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (state_q == S_FIN && load)
				ov_q <= 1'b1;
			else if (result.ready)
				ov_q <= 1'b0;

			if (wr_en) begin
				case (wr_index)
					REG_MODE:      mode_q  <= wr_data[0];
					REG_FREQ_STEP: fstep_q <= wr_data;
					REG_FREQ_MAX:  fmax_q  <= wr_data[7:0];
					REG_SWEEP_F0:  f0_q    <= wr_data[14:0];
					REG_SWEEP_RT:  rate_q  <= wr_data[14:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					op_q    <= item.operation;
					joint_q <= item.joint;
					ra_q    <= AW'(item.joint);
					inr_q   <= inr;
				end
			end
			S_RD: begin
				if (hit) begin
					ent_q <= ent_rd;
					if (!mode_q) begin
						f_q <= ent_rd.stepped_freq;
					end else begin
						prod_q <= 44'(rate_q) * 44'(ent_rd.phase_ticks);
						pass_q <= PASS_RR;
					end
				end else begin
					wt_q  <= '0;
					rep_q <= '0;
				end
			end
			S_FSW:  f_q <= (fs > 18'(SWEEP_CAP)) ? SWEEP_CAP : fs[15:0];
			S_MUL1: prod_q <= 44'(f_q) * 44'(ent_q.phase_ticks);
			S_MUL2: begin
				prod_q <= 44'(prod_q[31:0]) * 44'(PH_MUL);
				pass_q <= PASS_PH;
			end
			S_PREP: m_q <= (|pshr[40:23]) ? '1 : pshr[22:0];
			S_DIVA: rcp_q <= 41'(m_q) * 41'(RECIP_125);
			S_DIVB: q_q <= (chk > {1'b0, m_q}) ? q0 - 17'd1 : q0;
			S_WRAP: begin
				wt_q <= wt_n;
				if (!mode_q) begin
					rep_q <= 14'(rep10[19:8]);
					ent_q.phase_ticks <= wrap ? 16'd1 : t1;
					if (wrap)
						ent_q.stepped_ofs <= wt_n;
					if (st1 > STEP_PERIOD) begin
						ent_q.stepped_freq <= (nf > fcap) ? fcap : nf;
						ent_q.step_ticks   <= '0;
					end else begin
						ent_q.step_ticks   <= st1;
					end
				end else begin
					rep_q <= rep100[21:8];
					ent_q.step_ticks <= st1;
					if (wrap) begin
						ent_q.sweep_ofs   <= wt_n;
						ent_q.phase_ticks <= '0;
						prod_q <= 44'(rate_q) * 44'(t1);
						pass_q <= PASS_RR2;
					end else begin
						ent_q.phase_ticks <= t1;
					end
				end
			end
			S_UPD: ent_q.sweep_fofs <= (|fo_sum[17:16]) ? 16'hFFFF : fo_sum[15:0];
			S_FIN: begin
				if (load) begin
					oj_q  <= joint_q;
					oph_q <= wt_q;
					osn_q <= hit ? sres.value : '0;
					orp_q <= rep_q;
				end
			end
			default: ;
		endcase
	end

	ssp_sine u_sine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sine_go_q),
		.x      (wt_q),
		.res    (sres)
	);

	assign item.ready         = (state_q == S_IDLE);
	assign result.valid       = ov_q;
	assign result.joint_out   = oj_q;
	assign result.phase       = oph_q;
	assign result.sine_value  = osn_q;
	assign result.freq_report = orp_q;

`ifndef SYNTHESIS
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> state_q == S_RD)
		else $error("accepted item did not start a state read");

	a_sine_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sres.done |-> state_q == S_SINE)
		else $error("sine result outside of the sine wait");

	a_phase_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SINE |-> wt_q < PI_Q12)
		else $error("phase at or above pi after wrap");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && ov_q && !result.ready |=> state_q == S_FIN)
		else $error("write-back passed a stalled output register");

	a_drop_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(ov_q) |-> $past(result.ready))
		else $error("result item dropped without ready");
`endif

endmodule
